@@ hw/rtl/ppid_pkg.sv @@
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared widths, register indexes, mode codes, reset values and the
// configuration bundle of the positional PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ppid_pkg;

	// Default datapath sizes
	localparam int DATA_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF  = 32;

	// Fixed field widths
	localparam int GAIN_W        = 16;
	localparam int OUT_LIMIT_W   = 15;
	localparam int INTEG_LIMIT_W = 31;
	localparam int THRESH_W      = 16;
	localparam int MODE_W        = 2;
	localparam int DRIVE_W       = 16;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 31;

	// Q8.8 gains: the raw sum carries 8 fraction bits
	localparam int FRAC_BITS = 8;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_LIMIT    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIMIT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd6;

	// Mode codes; the spare code acts as the override mode
	localparam logic [MODE_W-1:0] MODE_PLAIN        = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OVERRIDE     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_OVERRIDE_ALT = 2'd3;

	// Reset values
	localparam logic [OUT_LIMIT_W-1:0]   OUT_LIMIT_RST   = 15'd32767;
	localparam logic [INTEG_LIMIT_W-1:0] INTEG_LIMIT_RST = 31'd100000;
	localparam logic [THRESH_W-1:0]      THRESH_RST      = 16'd1500;

	// Configuration bundle handed to the datapath
	typedef struct packed {
		logic signed [GAIN_W-1:0]   gain_p;
		logic signed [GAIN_W-1:0]   gain_i;
		logic signed [GAIN_W-1:0]   gain_d;
		logic [OUT_LIMIT_W-1:0]     output_limit;
		logic [INTEG_LIMIT_W-1:0]   integral_limit;
		logic [THRESH_W-1:0]        override_threshold;
		logic [MODE_W-1:0]          mode;
	} cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/ppid_integ.sv @@
// ----------------------------------------------------------------------------
// ppid_integ
// Error, saturating/clamped integral update and error difference. Holds the
// integral sum and the previous error, updated on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_integ #(
	parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = ppid_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic signed [DATA_WIDTH-1:0] target,
	input  wire logic signed [DATA_WIDTH-1:0] measured,
	input  wire ppid_pkg::cfg_t               cfg,
	output logic signed [DATA_WIDTH:0]        err,
	output logic signed [ACC_WIDTH-1:0]       sum_next,
	output logic signed [DATA_WIDTH+1:0]      diff
);
	import ppid_pkg::*;

	localparam int XW = ((ACC_WIDTH > DATA_WIDTH + 1) ? ACC_WIDTH : DATA_WIDTH + 1) + 1;
	localparam int LW = ((XW > INTEG_LIMIT_W + 1) ? XW : INTEG_LIMIT_W + 1) + 1;
	localparam logic signed [XW-1:0] ACC_MAX = (XW'(1) <<< (ACC_WIDTH - 1)) - XW'(1);
	localparam logic signed [XW-1:0] ACC_MIN = -ACC_MAX - XW'(1);

	logic signed [ACC_WIDTH-1:0]  sum_q;
	logic signed [DATA_WIDTH:0]   prev_err_q;
	logic signed [XW-1:0]         x;
	logic signed [ACC_WIDTH-1:0]  sat;
	logic signed [LW-1:0]         sat_l;
	logic signed [LW-1:0]         lim_l;
	logic signed [LW-1:0]         neg_lim_l;

	// Error and derivative term input
	assign err  = {target[DATA_WIDTH-1], target} - {measured[DATA_WIDTH-1], measured};
	assign diff = (DATA_WIDTH+2)'(err) - (DATA_WIDTH+2)'(prev_err_q);

	// Accumulator saturation; exactly the minimum lands one above it
	assign x = XW'(sum_q) + XW'(err);
	always_comb begin
		if (x > ACC_MAX) begin
			sat = ACC_MAX[ACC_WIDTH-1:0];
		end else if (x == ACC_MIN) begin
			sat = ACC_MIN[ACC_WIDTH-1:0] + ACC_WIDTH'(1);
		end else if (x < ACC_MIN) begin
			sat = ACC_MIN[ACC_WIDTH-1:0];
		end else begin
			sat = x[ACC_WIDTH-1:0];
		end
	end

	// Integral clamp, skipped in plain mode
	assign sat_l     = LW'(sat);
	assign lim_l     = LW'({1'b0, cfg.integral_limit});
	assign neg_lim_l = -lim_l;
	always_comb begin
		if (cfg.mode != MODE_PLAIN && sat_l > lim_l) begin
			sum_next = lim_l[ACC_WIDTH-1:0];
		end else if (cfg.mode != MODE_PLAIN && sat_l < neg_lim_l) begin
			sum_next = neg_lim_l[ACC_WIDTH-1:0];
		end else begin
			sum_next = sat;
		end
	end

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			prev_err_q <= '0;
		end else if (step) begin
			sum_q      <= sum_next;
			prev_err_q <= err;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ppid_drive.sv @@
// ----------------------------------------------------------------------------
// ppid_drive
// Gain products, Q8.8 scaling, output clamp and error override.
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_drive #(
	parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = ppid_pkg::ACC_WIDTH_DEF
) (
	input  wire logic signed [DATA_WIDTH:0]   err,
	input  wire logic signed [ACC_WIDTH-1:0]  sum,
	input  wire logic signed [DATA_WIDTH+1:0] diff,
	input  wire ppid_pkg::cfg_t               cfg,
	output logic signed [ppid_pkg::DRIVE_W-1:0] drive
);
	import ppid_pkg::*;

	localparam int TW    = (ACC_WIDTH > DATA_WIDTH + 2) ? ACC_WIDTH : DATA_WIDTH + 2;
	localparam int RAW_W = GAIN_W + TW + 2;
	localparam int CW    = ((DATA_WIDTH + 1 > THRESH_W + 1) ? DATA_WIDTH + 1 : THRESH_W + 1) + 1;

	logic signed [GAIN_W+DATA_WIDTH:0]   p_prod;
	logic signed [GAIN_W+ACC_WIDTH-1:0]  i_prod;
	logic signed [GAIN_W+DATA_WIDTH+1:0] d_prod;
	logic signed [RAW_W-1:0]             raw;
	logic signed [RAW_W-1:0]             scaled;
	logic signed [RAW_W-1:0]             lim_r;
	logic signed [RAW_W-1:0]             neg_lim_r;
	logic signed [RAW_W-1:0]             clamped;
	logic signed [CW-1:0]                err_c;
	logic signed [CW-1:0]                th_c;
	logic signed [CW-1:0]                neg_th_c;
	logic                                ovr_mode;

	// Three parallel products and their sum
	assign p_prod = $signed(cfg.gain_p) * err;
	assign i_prod = $signed(cfg.gain_i) * sum;
	assign d_prod = $signed(cfg.gain_d) * diff;
	assign raw    = RAW_W'(p_prod) + RAW_W'(i_prod) + RAW_W'(d_prod);

	// Floor shift and symmetric clamp
	assign scaled    = raw >>> FRAC_BITS;
	assign lim_r     = RAW_W'({1'b0, cfg.output_limit});
	assign neg_lim_r = -lim_r;
	always_comb begin
		if (scaled > lim_r) begin
			clamped = lim_r;
		end else if (scaled < neg_lim_r) begin
			clamped = neg_lim_r;
		end else begin
			clamped = scaled;
		end
	end

	// Large error forces full drive in override mode
	assign ovr_mode = (cfg.mode == MODE_OVERRIDE) || (cfg.mode == MODE_OVERRIDE_ALT);
	assign err_c    = CW'(err);
	assign th_c     = CW'({1'b0, cfg.override_threshold});
	assign neg_th_c = -th_c;
	always_comb begin
		if (ovr_mode && err_c > th_c) begin
			drive = lim_r[DRIVE_W-1:0];
		end else if (ovr_mode && err_c < neg_th_c) begin
			drive = neg_lim_r[DRIVE_W-1:0];
		end else begin
			drive = clamped[DRIVE_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/positional_pid_with_clamps.sv @@
// ----------------------------------------------------------------------------
// positional_pid_with_clamps
// Positional PID controller with integral and output clamps, Q8.8 gains.
//
//   channel  signals                          direction  accepted when
//   in       in_valid/in_ready, target/meas.  in         in_valid & in_ready
//   out      out_valid/out_ready, drive       out        out_valid & out_ready
//   cfg      cfg_we, cfg_index, cfg_wdata     in         cfg_we
//
// One word per cycle sustained while the output is not stalled; a word
// passes through three registers: input register, integral stage,
// product/clamp into the output register. The integral sum and previous error
// update as a word leaves the input register. Reset clears the pipeline valids
// and the controller state and loads the register defaults. A stalled output
// holds each stage in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_pid_with_clamps #(
	parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = ppid_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [DATA_WIDTH-1:0]         target,
	input  wire logic signed [DATA_WIDTH-1:0]         measured,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [ppid_pkg::DRIVE_W-1:0]       drive,
	input  wire logic                                 cfg_we,
	input  wire logic [ppid_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [ppid_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import ppid_pkg::*;

	localparam int SCW = ((ACC_WIDTH > INTEG_LIMIT_W + 1) ? ACC_WIDTH : INTEG_LIMIT_W + 1) + 1;

	cfg_t                          cfg_q;
	logic                          valid_s1;
	logic                          valid_s2;
	logic                          out_valid_q;
	logic signed [DATA_WIDTH-1:0]  target_s1;
	logic signed [DATA_WIDTH-1:0]  measured_s1;
	logic signed [DATA_WIDTH:0]    err_s2;
	logic signed [ACC_WIDTH-1:0]   sum_s2;
	logic signed [DATA_WIDTH+1:0]  diff_s2;
	logic signed [DRIVE_W-1:0]     drive_q;
	logic signed [DATA_WIDTH:0]    err_c;
	logic signed [ACC_WIDTH-1:0]   sum_c;
	logic signed [DATA_WIDTH+1:0]  diff_c;
	logic signed [DRIVE_W-1:0]     drive_c;
	logic                          in_fire;
	logic                          adv1;
	logic                          adv2;
	logic                          ready_s2;
	logic                          ready_s3;
	logic signed [SCW-1:0]         sum_chk;
	logic signed [SCW-1:0]         ilim_chk;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p             <= '0;
			cfg_q.gain_i             <= '0;
			cfg_q.gain_d             <= '0;
			cfg_q.output_limit       <= OUT_LIMIT_RST;
			cfg_q.integral_limit     <= INTEG_LIMIT_RST;
			cfg_q.override_threshold <= THRESH_RST;
			cfg_q.mode               <= MODE_OVERRIDE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:      cfg_q.gain_p             <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_I:      cfg_q.gain_i             <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_D:      cfg_q.gain_d             <= cfg_wdata[GAIN_W-1:0];
				REG_OUT_LIMIT:   cfg_q.output_limit       <= cfg_wdata[OUT_LIMIT_W-1:0];
				REG_INTEG_LIMIT: cfg_q.integral_limit     <= cfg_wdata[INTEG_LIMIT_W-1:0];
				REG_THRESHOLD:   cfg_q.override_threshold <= cfg_wdata[THRESH_W-1:0];
				REG_MODE:        cfg_q.mode               <= cfg_wdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign ready_s3 = !out_valid_q || out_ready;
	assign adv2     = valid_s2 && ready_s3;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign adv1     = valid_s1 && ready_s2;
	assign in_ready = !valid_s1 || ready_s2;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			target_s1   <= target;
			measured_s1 <= measured;
		end
		if (adv1) begin
			err_s2  <= err_c;
			sum_s2  <= sum_c;
			diff_s2 <= diff_c;
		end
		if (adv2) begin
			drive_q <= drive_c;
		end
	end

	// Integral stage
	ppid_integ #(
		.DATA_WIDTH(DATA_WIDTH),
		.ACC_WIDTH (ACC_WIDTH)
	) u_integ (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv1),
		.target  (target_s1),
		.measured(measured_s1),
		.cfg     (cfg_q),
		.err     (err_c),
		.sum_next(sum_c),
		.diff    (diff_c)
	);

	// Product and clamp stage
	ppid_drive #(
		.DATA_WIDTH(DATA_WIDTH),
		.ACC_WIDTH (ACC_WIDTH)
	) u_drive (
		.err  (err_s2),
		.sum  (sum_s2),
		.diff (diff_s2),
		.cfg  (cfg_q),
		.drive(drive_c)
	);

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// Comparison views for the checks below
	assign sum_chk  = SCW'(sum_s2);
	assign ilim_chk = SCW'({1'b0, cfg_q.integral_limit});

`ifndef SYNTHESIS
	// Clamped modes keep the integral within the limit in force at the update
	a_sum_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && cfg_q.mode != MODE_PLAIN && !cfg_we) |=>
		(sum_chk <= ilim_chk && sum_chk >= -ilim_chk))
		else $error("integral sum outside its clamp");

	// A word leaving the integral stage shows up within the output limit
	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && !cfg_we) |=>
		(out_valid_q && drive_q <= $signed({1'b0, cfg_q.output_limit}) &&
		 drive_q >= -$signed({1'b0, cfg_q.output_limit})))
		else $error("drive outside output limit");

	// A blocked integral stage keeps its word
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready_s3) |=> (valid_s2 && $stable(sum_s2) && $stable(err_s2)))
		else $error("integral stage word lost while stalled");
`endif

endmodule

`default_nettype wire
